### sv/srd_pkg.sv
`default_nettype none

package srd_pkg;

  localparam int HighW      = 64;
  localparam int LowW       = 56;
  localparam int FieldW     = HighW + LowW;
  localparam int RecW       = 3 * FieldW;
  localparam int KeyW       = FieldW;
  localparam int PosW       = 4;
  localparam int MaxResults = 16;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_LISTED = 2'd2,
    ST_EMPTY  = 2'd3
  } srd_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT0,
    S_RESP,
    S_LIST
  } srd_state_t;

  // read address sources
  typedef enum logic [1:0] {
    RD_TOP,
    RD_ZERO,
    RD_DEC,
    RD_INC
  } srd_rd_sel_t;

  // write address/data sources
  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW_UP,
    WR_NEW0
  } srd_wr_sel_t;

  typedef struct packed {
    logic in_fire;
    logic func_list;
    logic full;
    logic empty;
    logic key_gt;
    logic idx_zero;
    logic list_last;
    logic out_free;
  } srd_stat_t;

  typedef struct packed {
    logic        in_ready;
    logic        rd_en;
    srd_rd_sel_t rd_sel;
    logic        wr_en;
    srd_wr_sel_t wr_sel;
    logic        cnt_inc;
    logic        resp_set;
    srd_status_t resp_code;
    logic        out_load;
    logic        out_list;
  } srd_cmd_t;

endpackage

`default_nettype wire

### sv/srd_ifs.sv
`default_nettype none

interface srd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [srd_pkg::HighW-1:0]  name_high;
  logic [srd_pkg::LowW-1:0]   name_low;
  logic [srd_pkg::HighW-1:0]  surname_high;
  logic [srd_pkg::LowW-1:0]   surname_low;
  logic [srd_pkg::HighW-1:0]  phone_high;
  logic [srd_pkg::LowW-1:0]   phone_low;

  modport source (output valid, func, name_high, name_low, surname_high, surname_low,
                  phone_high, phone_low, input ready);
  modport sink   (input valid, func, name_high, name_low, surname_high, surname_low,
                  phone_high, phone_low, output ready);
endinterface

interface srd_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [srd_pkg::PosW-1:0]   position;
  logic [srd_pkg::HighW-1:0]  out_name_high;
  logic [srd_pkg::LowW-1:0]   out_name_low;
  logic [srd_pkg::HighW-1:0]  out_surname_high;
  logic [srd_pkg::LowW-1:0]   out_surname_low;
  logic [srd_pkg::HighW-1:0]  out_phone_high;
  logic [srd_pkg::LowW-1:0]   out_phone_low;
  logic                       last;

  modport source (output valid, status, position, out_name_high, out_name_low,
                  out_surname_high, out_surname_low, out_phone_high, out_phone_low,
                  last, input ready);
  modport sink   (input valid, status, position, out_name_high, out_name_low,
                  out_surname_high, out_surname_low, out_phone_high, out_phone_low,
                  last, output ready);
endinterface

`default_nettype wire

### sv/srd_ram.sv
`default_nettype none

module srd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output      logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/srd_ctrl.sv
`default_nettype none

module srd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srd_pkg::srd_stat_t stat,
  output      srd_pkg::srd_cmd_t  cmd
);

  srd_pkg::srd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srd_pkg::S_IDLE: begin
        if (stat.in_fire) begin
          if (!stat.func_list) begin
            if (stat.full) begin
              state_nxt = srd_pkg::S_RESP;
            end else if (stat.empty) begin
              state_nxt = srd_pkg::S_PUT0;
            end else begin
              state_nxt = srd_pkg::S_SCAN;
            end
          end else if (stat.empty) begin
            state_nxt = srd_pkg::S_RESP;
          end else begin
            state_nxt = srd_pkg::S_LIST;
          end
        end
      end
      srd_pkg::S_SCAN: begin
        if (stat.key_gt) begin
          if (stat.idx_zero) begin
            state_nxt = srd_pkg::S_PUT0;
          end
        end else begin
          state_nxt = srd_pkg::S_RESP;
        end
      end
      srd_pkg::S_PUT0: state_nxt = srd_pkg::S_RESP;
      srd_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_nxt = srd_pkg::S_IDLE;
        end
      end
      srd_pkg::S_LIST: begin
        if (stat.out_free && stat.list_last) begin
          state_nxt = srd_pkg::S_IDLE;
        end
      end
      default: state_nxt = srd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = srd_pkg::RD_TOP;
    cmd.wr_sel    = srd_pkg::WR_NEW0;
    cmd.resp_code = srd_pkg::ST_ADDED;
    case (state_r)
      srd_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_fire) begin
          if (!stat.func_list) begin
            if (stat.full) begin
              cmd.resp_set  = 1'b1;
              cmd.resp_code = srd_pkg::ST_FULL;
            end else if (!stat.empty) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = srd_pkg::RD_TOP;
            end
          end else if (stat.empty) begin
            cmd.resp_set  = 1'b1;
            cmd.resp_code = srd_pkg::ST_EMPTY;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = srd_pkg::RD_ZERO;
          end
        end
      end
      srd_pkg::S_SCAN: begin
        cmd.wr_en = 1'b1;
        if (stat.key_gt) begin
          // move the larger entry up one slot, fetch the next one down
          cmd.wr_sel = srd_pkg::WR_SHIFT;
          if (!stat.idx_zero) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = srd_pkg::RD_DEC;
          end
        end else begin
          cmd.wr_sel    = srd_pkg::WR_NEW_UP;
          cmd.cnt_inc   = 1'b1;
          cmd.resp_set  = 1'b1;
          cmd.resp_code = srd_pkg::ST_ADDED;
        end
      end
      srd_pkg::S_PUT0: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = srd_pkg::WR_NEW0;
        cmd.cnt_inc   = 1'b1;
        cmd.resp_set  = 1'b1;
        cmd.resp_code = srd_pkg::ST_ADDED;
      end
      srd_pkg::S_RESP: begin
        cmd.out_load = stat.out_free;
      end
      srd_pkg::S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_list = 1'b1;
          if (!stat.list_last) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = srd_pkg::RD_INC;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/sorted_record_directory_top.sv
// Sorted record directory: keeps up to CAPACITY records (name, surname, phone,
// 15 bytes each) in ascending name order in one synchronous RAM.
//
// Channels: in_if carries one word per command (func 0 = add, func 1 = list);
// out_if returns result words, with last set on the final word of a command.
// Both use valid/ready; a word moves when both are high.
// Add: the sequencer walks the RAM from the highest entry down, one entry a
// cycle, moving each entry whose name is greater up one slot, then writes
// the new record into the gap. A full directory drops the record and
// reports it. Equal names keep arrival order.
// List: records leave one per cycle while the receiver takes them, at most
// 16 records; an empty directory gives one status word.
// The RAM's single read port sets the one-entry-per-cycle pace.
// One command is in work at a time; in_if.ready drops from accept until the
// last result is in the output register, so the next command can be taken
// while that word still waits. A stalled receiver holds the output register
// and pauses the listing walk. Reset clears the entry count and the control
// state; the RAM contents are not cleared and are never read unwritten.

`default_nettype none

module sorted_record_directory_top #(
  parameter int CAPACITY = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  srd_in_if.sink   in_if,
  srd_out_if.source out_if
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = CW + 5;

  srd_pkg::srd_stat_t stat;
  srd_pkg::srd_cmd_t  cmd;

  logic [CW-1:0]            count_r;
  logic [IW-1:0]            idx_r;
  logic [srd_pkg::RecW-1:0] rec_r;
  srd_pkg::srd_status_t     resp_r;

  logic                     out_valid_r;
  logic [srd_pkg::RecW-1:0] out_rec_r;
  srd_pkg::srd_status_t     out_status_r;
  logic [srd_pkg::PosW-1:0] out_pos_r;
  logic                     out_last_r;

  logic [IW-1:0]            rd_addr;
  logic [IW-1:0]            wr_addr;
  logic [srd_pkg::RecW-1:0] wr_data;
  logic [srd_pkg::RecW-1:0] rd_data;
  logic [IW-1:0]            idx_up;
  logic [LW-1:0]            list_n;
  logic [LW-1:0]            idx_next_l;
  logic                     in_fire;
  logic                     out_free;

  assign in_fire  = in_if.valid && cmd.in_ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign idx_up   = IW'(idx_r + 1'b1);

  // listing stops after the stored entries or after 16 words
  assign idx_next_l = LW'(idx_r) + LW'(1);
  assign list_n     = (LW'(count_r) > LW'(srd_pkg::MaxResults)) ?
                      LW'(srd_pkg::MaxResults) : LW'(count_r);

  always_comb begin
    stat.in_fire   = in_fire;
    stat.func_list = in_if.func;
    stat.full      = (count_r == CW'(CAPACITY));
    stat.empty     = (count_r == '0);
    stat.key_gt    = rd_data[srd_pkg::RecW-1 -: srd_pkg::KeyW] >
                     rec_r[srd_pkg::RecW-1 -: srd_pkg::KeyW];
    stat.idx_zero  = (idx_r == '0);
    stat.list_last = (idx_next_l == list_n);
    stat.out_free  = out_free;
  end

  srd_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  always_comb begin
    case (cmd.rd_sel)
      srd_pkg::RD_TOP:  rd_addr = IW'(count_r - 1'b1);
      srd_pkg::RD_ZERO: rd_addr = '0;
      srd_pkg::RD_DEC:  rd_addr = IW'(idx_r - 1'b1);
      srd_pkg::RD_INC:  rd_addr = idx_up;
      default:          rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      srd_pkg::WR_SHIFT: begin
        wr_addr = idx_up;
        wr_data = rd_data;
      end
      srd_pkg::WR_NEW_UP: begin
        wr_addr = idx_up;
        wr_data = rec_r;
      end
      default: begin
        wr_addr = '0;
        wr_data = rec_r;
      end
    endcase
  end

  srd_ram #(
    .Width(srd_pkg::RecW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: capture the new record, track the walk index, hold results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_r <= {in_if.name_high, in_if.name_low, in_if.surname_high,
                in_if.surname_low, in_if.phone_high, in_if.phone_low};
    end
    if (cmd.rd_en) begin
      idx_r <= rd_addr;
    end
    if (cmd.resp_set) begin
      resp_r <= cmd.resp_code;
    end
    if (cmd.out_load) begin
      if (cmd.out_list) begin
        out_rec_r    <= rd_data;
        out_status_r <= srd_pkg::ST_LISTED;
        out_pos_r    <= srd_pkg::PosW'(idx_r);
        out_last_r   <= stat.list_last;
      end else begin
        out_rec_r    <= '0;
        out_status_r <= resp_r;
        out_pos_r    <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign in_if.ready             = cmd.in_ready;
  assign out_if.valid            = out_valid_r;
  assign out_if.status           = out_status_r;
  assign out_if.position         = out_pos_r;
  assign out_if.last             = out_last_r;
  assign {out_if.out_name_high, out_if.out_name_low, out_if.out_surname_high,
          out_if.out_surname_low, out_if.out_phone_high,
          out_if.out_phone_low} = out_rec_r;

endmodule

`default_nettype wire

### sv/srd_checker.sv
`default_nettype none

module srd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [3:0] out_position,
  input wire logic       out_last
);

  // hold a result word until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // status-only words close their command and carry rank zero
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != srd_pkg::ST_LISTED |-> out_last && out_position == '0)
    else $error("status word without last or with nonzero rank");

  // one command in work at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in work");

  // a listing in progress keeps the input closed
  a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input opened before listing finished");

endmodule

bind sorted_record_directory_top srd_checker u_srd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_status  (out_if.status),
  .out_position(out_if.position),
  .out_last    (out_if.last)
);

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;

  localparam int Capacity = 16;
  // Long receiver hold-off, in cycles, for the backpressure test.
  localparam int unsigned LongHold = 400;

  // One stored record, laid out as on the channels.
  typedef struct {
    logic [srd_pkg::HighW-1:0] nh;
    logic [srd_pkg::LowW-1:0]  nl;
    logic [srd_pkg::HighW-1:0] sh;
    logic [srd_pkg::LowW-1:0]  sl;
    logic [srd_pkg::HighW-1:0] ph;
    logic [srd_pkg::LowW-1:0]  pl;
  } dir_entry_t;

  // One result word as it should leave the block.
  typedef struct {
    srd_pkg::srd_status_t     status;
    logic [srd_pkg::PosW-1:0] pos;
    dir_entry_t               rec;
    logic                     last;
  } dir_word_t;

  logic clk;
  logic rst_n;

  srd_in_if  in_bus ();
  srd_out_if out_bus ();

  sorted_record_directory_top #(.CAPACITY(Capacity)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // Shadow of the directory: records in name order and the fill level.
  dir_entry_t  dir_ent [Capacity];
  int unsigned dir_count;

  // Result words still owed by the block, oldest first.
  dir_word_t   pending_words [$];
  int unsigned mismatches;

  // Idle controls for the sender and the receiver, and the hold-off requests.
  bit          tx_idle;
  bit          rx_idle;
  int unsigned hold_requests;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Bound the run; a correct run ends far earlier.
  initial begin
    #12_000_000;
    $display("tb: errors");
    $finish;
  end

  // Gap length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [srd_pkg::LowW-1:0] rand56();
    return srd_pkg::LowW'({$urandom, $urandom});
  endfunction

  function automatic dir_entry_t make_entry(
      logic [srd_pkg::HighW-1:0] nh, logic [srd_pkg::LowW-1:0] nl,
      logic [srd_pkg::HighW-1:0] sh, logic [srd_pkg::LowW-1:0] sl,
      logic [srd_pkg::HighW-1:0] ph, logic [srd_pkg::LowW-1:0] pl);
    dir_entry_t e;
    e.nh = nh; e.nl = nl; e.sh = sh; e.sl = sl; e.ph = ph; e.pl = pl;
    return e;
  endfunction

  // Random record whose name often collides with, or sits next to, a stored one
  // so that ties and low-half compares come up often.
  function automatic dir_entry_t random_entry();
    dir_entry_t  e;
    int unsigned r;
    int unsigned pick;
    e = make_entry(rand64(), rand56(), rand64(), rand56(), rand64(), rand56());
    r = $urandom_range(99);
    if (dir_count != 0) begin
      pick = $urandom_range(dir_count - 1);
      if (r < 25) begin
        e.nh = dir_ent[pick].nh;
        e.nl = dir_ent[pick].nl;
      end else if (r < 45) begin
        e.nh = dir_ent[pick].nh;
      end
    end
    if (r >= 45 && r < 60) begin
      // short ASCII-like names, zero padded
      e.nh = {8'($urandom_range(8'h5a, 8'h41)), 8'($urandom_range(8'h7a, 8'h61)), 48'h0};
      e.nl = '0;
    end
    return e;
  endfunction

  // Predict the words caused by one accepted command and update the shadow.
  task automatic predict_directory(input logic func, input dir_entry_t e);
    dir_word_t   w;
    int unsigned slot;
    w.rec = make_entry('0, '0, '0, '0, '0, '0);
    w.pos = '0;
    w.last = 1'b1;
    if (func == 1'b0) begin
      if (dir_count >= Capacity) begin
        w.status = srd_pkg::ST_FULL;
      end else begin
        // The greater names form a suffix; land before the first of them.
        slot = dir_count;
        for (int k = int'(dir_count) - 1; k >= 0; k--)
          if ({dir_ent[k].nh, dir_ent[k].nl} > {e.nh, e.nl}) slot = k;
        for (int k = int'(dir_count); k > int'(slot); k--)
          dir_ent[k] = dir_ent[k-1];
        dir_ent[slot] = e;
        dir_count++;
        w.status = srd_pkg::ST_ADDED;
      end
      pending_words.push_back(w);
    end else if (dir_count == 0) begin
      w.status = srd_pkg::ST_EMPTY;
      pending_words.push_back(w);
    end else begin
      for (int k = 0; k < dir_count && k < srd_pkg::MaxResults; k++) begin
        w.status = srd_pkg::ST_LISTED;
        w.pos = k[srd_pkg::PosW-1:0];
        w.rec = dir_ent[k];
        w.last = (k + 1 == dir_count) || (k + 1 == srd_pkg::MaxResults);
        pending_words.push_back(w);
      end
    end
  endtask

  // Offer one command word and hold it until the block takes it. Valid stays
  // high into the next word when no gap is drawn.
  task automatic send_word(input logic func, input dir_entry_t e);
    int unsigned gap;
    gap = pick_gap(tx_idle);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.func         <= func;
    in_bus.name_high    <= e.nh;
    in_bus.name_low     <= e.nl;
    in_bus.surname_high <= e.sh;
    in_bus.surname_low  <= e.sl;
    in_bus.phone_high   <= e.ph;
    in_bus.phone_low    <= e.pl;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_directory(func, e);
  endtask

  // List fields are ignored by the block; drive noise on them anyway.
  task automatic send_list();
    send_word(1'b1, make_entry(rand64(), rand56(), rand64(), rand56(), rand64(), rand56()));
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $realtime, what, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    dir_word_t w;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word, status expected none got %h", $realtime,
                 out_bus.status);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        check_field("status",       64'(w.status),   64'(out_bus.status));
        check_field("position",     64'(w.pos),      64'(out_bus.position));
        check_field("name_high",    w.rec.nh,        out_bus.out_name_high);
        check_field("name_low",     64'(w.rec.nl),   64'(out_bus.out_name_low));
        check_field("surname_high", w.rec.sh,        out_bus.out_surname_high);
        check_field("surname_low",  64'(w.rec.sl),   64'(out_bus.out_surname_low));
        check_field("phone_high",   w.rec.ph,        out_bus.out_phone_high);
        check_field("phone_low",    64'(w.rec.pl),   64'(out_bus.out_phone_low));
        check_field("last",         64'(w.last),     64'(out_bus.last));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off per request, counted here.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = LongHold;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(rx_idle);
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Listing an empty directory gives a single empty-status word.
  task automatic test_empty_list();
    send_list();
  endtask

  // Hand-picked names: extremes, ties, and names that differ only in the low
  // half. List now and then to see each shift land.
  task automatic test_directed_inserts();
    logic [srd_pkg::HighW-1:0] maria_hi;
    maria_hi = 64'h4d41_5249_4100_0000;
    send_word(1'b0, make_entry(maria_hi, 56'h20_0000_0000_0000,
                               64'h524f_5353_4900_0000, '0, 64'h3535_3531_3233_3400, '0));
    send_list();
    send_word(1'b0, make_entry('1, '1, '1, '1, '1, '1));
    send_word(1'b0, make_entry('0, '0, '0, '0, '0, '0));
    // same name again: must land after the first one
    send_word(1'b0, make_entry(maria_hi, 56'h20_0000_0000_0000,
                               64'h4249_414e_4348_4900, 56'h1, 64'h3939_3900_0000_0000, '1));
    // same upper half, smaller and larger lower half
    send_word(1'b0, make_entry(maria_hi, '0, rand64(), rand56(), rand64(), rand56()));
    send_word(1'b0, make_entry(maria_hi, '1, rand64(), rand56(), rand64(), rand56()));
    send_list();
    // ties at both ends of the key range
    send_word(1'b0, make_entry('1, '1, 64'h1, 56'h2, 64'h3, 56'h4));
    send_word(1'b0, make_entry('0, '0, 64'h5, 56'h6, 64'h7, 56'h8));
    send_list();
  endtask

  // Fill the rest of the directory with random names, listing in between.
  task automatic test_fill_random();
    while (dir_count < Capacity) begin
      if ($urandom_range(99) < 70) send_word(1'b0, random_entry());
      else send_list();
    end
    send_list();
  endtask

  // A full directory drops every add, whatever the name.
  task automatic test_full_drop();
    send_word(1'b0, make_entry('0, '0, '0, '0, '0, '0));
    send_word(1'b0, make_entry('1, '1, '1, '1, '1, '1));
    send_word(1'b0, random_entry());
    send_list();
  endtask

  // Hold the receiver off for a long stretch while commands keep coming, so
  // the output register fills and the input stalls.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_requests++;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_word(1'b0, random_entry());
      else send_list();
    end
    tx_idle = 1'b1;
  endtask

  // Random mix of lists and dropped adds, in blocks with and without idling.
  task automatic test_random_mix();
    for (int i = 0; i < 330; i++) begin
      if (i % 40 == 0) begin
        tx_idle = ($urandom_range(3) != 0);
        rx_idle = ($urandom_range(3) != 0);
      end
      if ($urandom_range(1)) send_list();
      else send_word(1'b0, random_entry());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.func         = 1'b0;
    in_bus.name_high    = '0;
    in_bus.name_low     = '0;
    in_bus.surname_high = '0;
    in_bus.surname_low  = '0;
    in_bus.phone_high   = '0;
    in_bus.phone_low    = '0;
    out_bus.ready       = 1'b0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    hold_requests       = 0;
    dir_count           = 0;
    mismatches          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_directed_inserts();
    test_fill_random();
    test_full_drop();
    test_backpressure();
    test_random_mix();
    in_bus.valid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (Capacity + 8) @(posedge clk);

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
